// File: rtl/eul_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eul_pkg;

  // default parameter values
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int ELEMENT_BITS_DEF  = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // internal fixed point: sine/cosine in Q.30, angle path wider for folding
  localparam int SC_W = 32;
  localparam int Z_W  = 34;

  localparam logic signed [SC_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [Z_W-1:0]  PI_Q        = 34'sd3373259426;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q   = 34'sd1686629713;

  // Euler order codes
  typedef enum logic [2:0] {
    ORD_XYZ = 3'd0,
    ORD_XZY = 3'd1,
    ORD_YXZ = 3'd2,
    ORD_YZX = 3'd3,
    ORD_ZXY = 3'd4,
    ORD_ZYX = 3'd5
  } ord_t;

  // atan(2^-i) in Q.30, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      25: v = 34'sd32;
      26: v = 34'sd16;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // Q.30 product with floor shift
  function automatic logic signed [SC_W-1:0] mul_q30(input logic signed [SC_W-1:0] a,
                                                     input logic signed [SC_W-1:0] b);
    logic signed [2*SC_W-1:0] p;
    p = a * b;
    return p[SC_W+29:30];
  endfunction

endpackage
`default_nettype wire

// File: rtl/eul_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module eul_cordic #(
  parameter int ANGLE_BITS    = eul_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = eul_pkg::CORDIC_STAGES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  input  wire  signed [ANGLE_BITS-1:0]        angle,
  output logic                                out_valid,
  output logic signed [eul_pkg::SC_W-1:0]     sin_val,
  output logic signed [eul_pkg::SC_W-1:0]     cos_val
);
  localparam int SH = 33 - ANGLE_BITS;

  logic signed [eul_pkg::Z_W-1:0]  wide;
  logic                            vld  [0:CORDIC_STAGES];
  logic                            flip [0:CORDIC_STAGES];
  logic signed [eul_pkg::SC_W-1:0] x    [0:CORDIC_STAGES];
  logic signed [eul_pkg::SC_W-1:0] y    [0:CORDIC_STAGES];
  logic signed [eul_pkg::Z_W-1:0]  z    [0:CORDIC_STAGES];

  // widen angle to Q.30
  assign wide = eul_pkg::Z_W'(angle) <<< SH;

  // fold angle into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x[0] <= eul_pkg::CORDIC_GAIN;
    y[0] <= '0;
    if (wide > eul_pkg::HALF_PI_Q) begin
      z[0]    <= wide - eul_pkg::PI_Q;
      flip[0] <= 1'b1;
    end else if (wide < -eul_pkg::HALF_PI_Q) begin
      z[0]    <= wide + eul_pkg::PI_Q;
      flip[0] <= 1'b1;
    end else begin
      z[0]    <= wide;
      flip[0] <= 1'b0;
    end
  end

  // one micro-rotation per register stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      flip[i+1] <= flip[i];
      if (!z[i][eul_pkg::Z_W-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - eul_pkg::atan_q30(i);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + eul_pkg::atan_q30(i);
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    cos_val <= flip[CORDIC_STAGES] ? -x[CORDIC_STAGES] : x[CORDIC_STAGES];
    sin_val <= flip[CORDIC_STAGES] ? -y[CORDIC_STAGES] : y[CORDIC_STAGES];
  end
endmodule
`default_nettype wire

// File: rtl/eul_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
module eul_matrix #(
  parameter int ELEMENT_BITS = eul_pkg::ELEMENT_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  input  wire  [2:0]                         cmd,
  input  wire  signed [eul_pkg::SC_W-1:0]    sx,
  input  wire  signed [eul_pkg::SC_W-1:0]    cx,
  input  wire  signed [eul_pkg::SC_W-1:0]    sy,
  input  wire  signed [eul_pkg::SC_W-1:0]    cy,
  input  wire  signed [eul_pkg::SC_W-1:0]    sz,
  input  wire  signed [eul_pkg::SC_W-1:0]    cz,
  output logic                               out_valid,
  output logic signed [ELEMENT_BITS-1:0]     r00,
  output logic signed [ELEMENT_BITS-1:0]     r01,
  output logic signed [ELEMENT_BITS-1:0]     r02,
  output logic signed [ELEMENT_BITS-1:0]     r10,
  output logic signed [ELEMENT_BITS-1:0]     r11,
  output logic signed [ELEMENT_BITS-1:0]     r12,
  output logic signed [ELEMENT_BITS-1:0]     r20,
  output logic signed [ELEMENT_BITS-1:0]     r21,
  output logic signed [ELEMENT_BITS-1:0]     r22
);
  localparam int W  = eul_pkg::SC_W;
  localparam int SW = eul_pkg::Z_W;
  localparam int SH = 32 - ELEMENT_BITS;
  localparam logic signed [SW-1:0] HALF = SW'((64'd1 << SH) >> 1);
  localparam logic signed [SW-1:0] LIM  = SW'(64'd1 << (ELEMENT_BITS - 2));

  function automatic logic signed [SW-1:0] ext(input logic signed [W-1:0] a);
    return SW'(a);
  endfunction

  function automatic logic signed [ELEMENT_BITS-1:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + HALF) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[ELEMENT_BITS-1:0];
  endfunction

  // stage A: pair products
  logic a_vld;
  logic [2:0] a_cmd;
  logic signed [W-1:0] a_sx, a_sy, a_sz;
  logic signed [W-1:0] a_cycz, a_sxsy, a_cxcy, a_cysx, a_cxsy, a_cxcz;
  logic signed [W-1:0] a_czsx, a_czsy, a_sysz, a_sxsz, a_cxsz, a_cysz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_cmd  <= cmd;
    a_sx   <= sx;
    a_sy   <= sy;
    a_sz   <= sz;
    a_cycz <= eul_pkg::mul_q30(cy, cz);
    a_sxsy <= eul_pkg::mul_q30(sx, sy);
    a_cxcy <= eul_pkg::mul_q30(cx, cy);
    a_cysx <= eul_pkg::mul_q30(cy, sx);
    a_cxsy <= eul_pkg::mul_q30(cx, sy);
    a_cxcz <= eul_pkg::mul_q30(cx, cz);
    a_czsx <= eul_pkg::mul_q30(cz, sx);
    a_czsy <= eul_pkg::mul_q30(cz, sy);
    a_sysz <= eul_pkg::mul_q30(sy, sz);
    a_sxsz <= eul_pkg::mul_q30(sx, sz);
    a_cxsz <= eul_pkg::mul_q30(cx, sz);
    a_cysz <= eul_pkg::mul_q30(cy, sz);
  end

  // stage B: triple products, pass pairs along
  logic b_vld;
  logic [2:0] b_cmd;
  logic signed [W-1:0] b_sx, b_sy, b_sz;
  logic signed [W-1:0] b_cycz, b_sxsy, b_cxcy, b_cysx, b_cxsy, b_cxcz;
  logic signed [W-1:0] b_czsx, b_czsy, b_sysz, b_sxsz, b_cxsz, b_cysz;
  logic signed [W-1:0] t_cxcy_sz, t_cysx_sz, t_sxsy_sz, t_czsx_sy;
  logic signed [W-1:0] t_cycz_sx, t_cxsy_sz, t_cxcz_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_cmd     <= a_cmd;
    b_sx      <= a_sx;
    b_sy      <= a_sy;
    b_sz      <= a_sz;
    b_cycz    <= a_cycz;
    b_sxsy    <= a_sxsy;
    b_cxcy    <= a_cxcy;
    b_cysx    <= a_cysx;
    b_cxsy    <= a_cxsy;
    b_cxcz    <= a_cxcz;
    b_czsx    <= a_czsx;
    b_czsy    <= a_czsy;
    b_sysz    <= a_sysz;
    b_sxsz    <= a_sxsz;
    b_cxsz    <= a_cxsz;
    b_cysz    <= a_cysz;
    t_cxcy_sz <= eul_pkg::mul_q30(a_cxcy, a_sz);
    t_cysx_sz <= eul_pkg::mul_q30(a_cysx, a_sz);
    t_sxsy_sz <= eul_pkg::mul_q30(a_sxsy, a_sz);
    t_czsx_sy <= eul_pkg::mul_q30(a_czsx, a_sy);
    t_cycz_sx <= eul_pkg::mul_q30(a_cycz, a_sx);
    t_cxsy_sz <= eul_pkg::mul_q30(a_cxsy, a_sz);
    t_cxcz_sy <= eul_pkg::mul_q30(a_cxcz, a_sy);
  end

  // stage C: combine terms for the selected order
  logic c_vld;
  logic signed [SW-1:0] s_next [0:8];
  logic signed [SW-1:0] s      [0:8];

  always_comb begin
    case (b_cmd)
      eul_pkg::ORD_XZY: begin
        s_next[0] = ext(b_cycz);
        s_next[1] = ext(b_sxsy) - ext(t_cxcy_sz);
        s_next[2] = ext(b_cxsy) + ext(t_cysx_sz);
        s_next[3] = ext(b_sz);
        s_next[4] = ext(b_cxcz);
        s_next[5] = -ext(b_czsx);
        s_next[6] = -ext(b_czsy);
        s_next[7] = ext(b_cysx) + ext(t_cxsy_sz);
        s_next[8] = ext(b_cxcy) - ext(t_sxsy_sz);
      end
      eul_pkg::ORD_YXZ: begin
        s_next[0] = ext(b_cycz) - ext(t_sxsy_sz);
        s_next[1] = -ext(b_cxsz);
        s_next[2] = ext(b_czsy) + ext(t_cysx_sz);
        s_next[3] = ext(t_czsx_sy) + ext(b_cysz);
        s_next[4] = ext(b_cxcz);
        s_next[5] = -ext(t_cycz_sx) + ext(b_sysz);
        s_next[6] = -ext(b_cxsy);
        s_next[7] = ext(b_sx);
        s_next[8] = ext(b_cxcy);
      end
      eul_pkg::ORD_YZX: begin
        s_next[0] = ext(b_cycz);
        s_next[1] = -ext(b_sz);
        s_next[2] = ext(b_czsy);
        s_next[3] = ext(t_cxcy_sz) + ext(b_sxsy);
        s_next[4] = ext(b_cxcz);
        s_next[5] = ext(t_cxsy_sz) - ext(b_cysx);
        s_next[6] = ext(t_cysx_sz) - ext(b_cxsy);
        s_next[7] = ext(b_czsx);
        s_next[8] = ext(t_sxsy_sz) + ext(b_cxcy);
      end
      eul_pkg::ORD_ZXY: begin
        s_next[0] = ext(b_cycz) + ext(t_sxsy_sz);
        s_next[1] = ext(t_czsx_sy) - ext(b_cysz);
        s_next[2] = ext(b_cxsy);
        s_next[3] = ext(b_cxsz);
        s_next[4] = ext(b_cxcz);
        s_next[5] = -ext(b_sx);
        s_next[6] = -ext(b_czsy) + ext(t_cysx_sz);
        s_next[7] = ext(t_cycz_sx) + ext(b_sysz);
        s_next[8] = ext(b_cxcy);
      end
      eul_pkg::ORD_ZYX: begin
        s_next[0] = ext(b_cycz);
        s_next[1] = -ext(b_cysz);
        s_next[2] = ext(b_sy);
        s_next[3] = ext(t_czsx_sy) + ext(b_cxsz);
        s_next[4] = ext(b_cxcz) - ext(t_sxsy_sz);
        s_next[5] = -ext(b_cysx);
        s_next[6] = -ext(t_cxcz_sy) + ext(b_sxsz);
        s_next[7] = ext(b_czsx) + ext(t_cxsy_sz);
        s_next[8] = ext(b_cxcy);
      end
      default: begin
        // XYZ and the unused codes
        s_next[0] = ext(b_cycz);
        s_next[1] = ext(t_czsx_sy) - ext(b_cxsz);
        s_next[2] = ext(t_cxcz_sy) + ext(b_sxsz);
        s_next[3] = ext(b_cysz);
        s_next[4] = ext(b_cxcz) + ext(t_sxsy_sz);
        s_next[5] = -ext(b_czsx) + ext(t_cxsy_sz);
        s_next[6] = -ext(b_sy);
        s_next[7] = ext(b_cysx);
        s_next[8] = ext(b_cxcy);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      s[k] <= s_next[k];
    end
  end

  // stage D: round and saturate to output format
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    r00 <= to_out(s[0]);
    r01 <= to_out(s[1]);
    r02 <= to_out(s[2]);
    r10 <= to_out(s[3]);
    r11 <= to_out(s[4]);
    r12 <= to_out(s[5]);
    r20 <= to_out(s[6]);
    r21 <= to_out(s[7]);
    r22 <= to_out(s[8]);
  end
endmodule
`default_nettype wire

// File: rtl/euler_to_rotation_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// Euler angles to 3x3 rotation matrix.
// Input beat: cmd selects the Euler order (XYZ, XZY, YXZ, YZX, ZXY, ZYX;
// codes 6 and 7 act as XYZ), angle_x/y/z are signed Q2.13 radians.
// A beat is taken on a rising edge with start high and busy low; busy is
// high only during reset, so a new beat may enter in every cycle.
// Result beat: r00..r22, signed Q1.14 saturated to +-1.0, shown for one
// cycle with done high. The receiver cannot stall; every result is taken.
// Pipeline: angle fold, one register per CORDIC micro-rotation, sign
// restore, pair products, triple products, order select and sum, round
// and saturate.
// Throughput: one beat per cycle, set by the three parallel CORDIC lanes
// and the fully pipelined multiplier stages.
// Reset clears all valid bits; beats in flight are dropped and no done
// pulse follows reset until a new beat is taken.
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS    = eul_pkg::ANGLE_BITS_DEF,
  parameter int ELEMENT_BITS  = eul_pkg::ELEMENT_BITS_DEF,
  parameter int CORDIC_STAGES = eul_pkg::CORDIC_STAGES_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire  [2:0]                      cmd,
  input  wire  signed [ANGLE_BITS-1:0]    angle_x,
  input  wire  signed [ANGLE_BITS-1:0]    angle_y,
  input  wire  signed [ANGLE_BITS-1:0]    angle_z,
  output logic                            done,
  output logic signed [ELEMENT_BITS-1:0]  r00,
  output logic signed [ELEMENT_BITS-1:0]  r01,
  output logic signed [ELEMENT_BITS-1:0]  r02,
  output logic signed [ELEMENT_BITS-1:0]  r10,
  output logic signed [ELEMENT_BITS-1:0]  r11,
  output logic signed [ELEMENT_BITS-1:0]  r12,
  output logic signed [ELEMENT_BITS-1:0]  r20,
  output logic signed [ELEMENT_BITS-1:0]  r21,
  output logic signed [ELEMENT_BITS-1:0]  r22
);
  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int LAT        = CORDIC_LAT + 4;
  localparam logic signed [ELEMENT_BITS-1:0] LIM = ELEMENT_BITS'(64'd1 << (ELEMENT_BITS - 2));

  logic accept;
  logic vx, vy, vz;
  logic signed [eul_pkg::SC_W-1:0] sx, cx, sy, cy, sz, cz;
  logic [2:0] cmd_pipe [0:CORDIC_LAT-1];

  assign busy   = rst;
  assign accept = start & ~busy;

  eul_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_x (
    .clk(clk), .rst(rst), .in_valid(accept), .angle(angle_x),
    .out_valid(vx), .sin_val(sx), .cos_val(cx)
  );

  eul_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_y (
    .clk(clk), .rst(rst), .in_valid(accept), .angle(angle_y),
    .out_valid(vy), .sin_val(sy), .cos_val(cy)
  );

  eul_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_z (
    .clk(clk), .rst(rst), .in_valid(accept), .angle(angle_z),
    .out_valid(vz), .sin_val(sz), .cos_val(cz)
  );

  // hold the order code alongside the CORDIC lanes
  always_ff @(posedge clk) begin
    cmd_pipe[0] <= cmd;
    for (int k = 1; k < CORDIC_LAT; k++) begin
      cmd_pipe[k] <= cmd_pipe[k-1];
    end
  end

  eul_matrix #(.ELEMENT_BITS(ELEMENT_BITS)) u_matrix (
    .clk(clk), .rst(rst), .in_valid(vx), .cmd(cmd_pipe[CORDIC_LAT-1]),
    .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
    .out_valid(done),
    .r00(r00), .r01(r01), .r02(r02),
    .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22)
  );

  // lanes run in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (vx == vy) && (vx == vz))
    else $error("CORDIC lane valid bits diverged");

  // every beat comes out after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted beat produced no result strobe");

  // no result strobe without a matching beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe does not match accepted beat");

  // saturated diagonal entries r00, r11 and r22 stay within +-1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (r00 <= LIM) && (r00 >= -LIM) && (r11 <= LIM) && (r11 >= -LIM)
             && (r22 <= LIM) && (r22 >= -LIM))
    else $error("matrix entry outside saturation range");
endmodule
`default_nettype wire

// File: bench/euler_to_rotation_matrix_tb.sv
`timescale 1ns / 1ps
module euler_to_rotation_matrix_tb;

  localparam int ANG_W      = 16;
  localparam int ELEM_W     = 16;
  localparam int LATENCY    = 22;
  localparam int TOLERANCE  = 4;
  localparam int CYCLE_CAP  = 100000;
  localparam longint FOLD_HALF = 64'sd1686629713;
  localparam longint FOLD_PI   = 64'sd3373259426;
  localparam longint GAIN_Q30  = 64'sd652032874;
  // Q2.13 value just past pi/2
  localparam int HALF_PI_Q13 = 12868;

  typedef logic [8:0][ELEM_W-1:0] matrix_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] cmd;
  logic signed [ANG_W-1:0] angle_x, angle_y, angle_z;
  logic done;
  logic signed [ELEM_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  matrix_t expected_mats[$];
  int errors;
  longint cycles;
  bit idle_allowed;

  longint atan_lut [16] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
    64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
    64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768
  };

  euler_to_rotation_matrix dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z), .done(done),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Q.30 product, floor shift
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  // fold by pi once, then run the micro-rotations
  function automatic void cordic_sincos(input logic signed [ANG_W-1:0] ang,
                                        output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = GAIN_Q30;
    y = 0;
    z = longint'(ang) * 131072;
    flip = 1'b0;
    if (z > FOLD_HALF) begin
      z = z - FOLD_PI;
      flip = 1'b1;
    end else if (z < -FOLD_HALF) begin
      z = z + FOLD_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_lut[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // round half up to Q1.14 and clamp to +-1.0
  function automatic logic [ELEM_W-1:0] round_sat(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[ELEM_W-1:0];
  endfunction

  function automatic matrix_t rotation_matrix(input logic [2:0] order,
      input logic signed [ANG_W-1:0] ax, input logic signed [ANG_W-1:0] ay,
      input logic signed [ANG_W-1:0] az);
    longint sx, cx, sy, cy, sz, cz;
    longint r [9];
    matrix_t m;
    cordic_sincos(ax, sx, cx);
    cordic_sincos(ay, sy, cy);
    cordic_sincos(az, sz, cz);
    case (order)
      eul_pkg::ORD_XZY: begin
        r[0] = qmul(cy, cz); r[1] = qmul(sx, sy) - qmul(qmul(cx, cy), sz);
        r[2] = qmul(cx, sy) + qmul(qmul(cy, sx), sz);
        r[3] = sz; r[4] = qmul(cx, cz); r[5] = -qmul(cz, sx);
        r[6] = -qmul(cz, sy); r[7] = qmul(cy, sx) + qmul(qmul(cx, sy), sz);
        r[8] = qmul(cx, cy) - qmul(qmul(sx, sy), sz);
      end
      eul_pkg::ORD_YXZ: begin
        r[0] = qmul(cy, cz) - qmul(qmul(sx, sy), sz); r[1] = -qmul(cx, sz);
        r[2] = qmul(cz, sy) + qmul(qmul(cy, sx), sz);
        r[3] = qmul(qmul(cz, sx), sy) + qmul(cy, sz); r[4] = qmul(cx, cz);
        r[5] = -qmul(qmul(cy, cz), sx) + qmul(sy, sz);
        r[6] = -qmul(cx, sy); r[7] = sx; r[8] = qmul(cx, cy);
      end
      eul_pkg::ORD_YZX: begin
        r[0] = qmul(cy, cz); r[1] = -sz; r[2] = qmul(cz, sy);
        r[3] = qmul(qmul(cx, cy), sz) + qmul(sx, sy); r[4] = qmul(cx, cz);
        r[5] = qmul(qmul(cx, sy), sz) - qmul(sx, cy);
        r[6] = qmul(qmul(sx, cy), sz) - qmul(cx, sy); r[7] = qmul(sx, cz);
        r[8] = qmul(qmul(sx, sy), sz) + qmul(cx, cy);
      end
      eul_pkg::ORD_ZXY: begin
        r[0] = qmul(cy, cz) + qmul(qmul(sx, sy), sz);
        r[1] = qmul(qmul(cz, sx), sy) - qmul(cy, sz); r[2] = qmul(cx, sy);
        r[3] = qmul(cx, sz); r[4] = qmul(cx, cz); r[5] = -sx;
        r[6] = -qmul(cz, sy) + qmul(qmul(cy, sx), sz);
        r[7] = qmul(qmul(cy, cz), sx) + qmul(sy, sz); r[8] = qmul(cx, cy);
      end
      eul_pkg::ORD_ZYX: begin
        r[0] = qmul(cy, cz); r[1] = -qmul(cy, sz); r[2] = sy;
        r[3] = qmul(qmul(cz, sx), sy) + qmul(cx, sz);
        r[4] = qmul(cx, cz) - qmul(qmul(sx, sy), sz); r[5] = -qmul(cy, sx);
        r[6] = -qmul(qmul(cx, cz), sy) + qmul(sx, sz);
        r[7] = qmul(cz, sx) + qmul(qmul(cx, sy), sz); r[8] = qmul(cx, cy);
      end
      default: begin
        // XYZ, also taken by the two unused codes
        r[0] = qmul(cy, cz); r[1] = qmul(qmul(cz, sx), sy) - qmul(cx, sz);
        r[2] = qmul(qmul(cx, cz), sy) + qmul(sx, sz);
        r[3] = qmul(cy, sz); r[4] = qmul(cx, cz) + qmul(qmul(sx, sy), sz);
        r[5] = -qmul(cz, sx) + qmul(qmul(cx, sy), sz);
        r[6] = -sy; r[7] = qmul(cy, sx); r[8] = qmul(cx, cy);
      end
    endcase
    for (int k = 0; k < 9; k++) m[k] = round_sat(r[k]);
    return m;
  endfunction

  // predict on every accepted input beat
  always @(posedge clk) begin
    if (!rst && start && !busy)
      expected_mats.push_back(rotation_matrix(cmd, angle_x, angle_y, angle_z));
  end

  // check every result beat against the oldest prediction
  always @(posedge clk) begin
    matrix_t got, want;
    int diff;
    if (!rst && done) begin
      got = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
      if (expected_mats.size() == 0) begin
        $display("%0t: unexpected result beat r00=%0d", $time, r00);
        errors++;
      end else begin
        want = expected_mats.pop_front();
        for (int k = 0; k < 9; k++) begin
          diff = int'($signed(got[k])) - int'($signed(want[k]));
          if (diff > TOLERANCE || diff < -TOLERANCE) begin
            $display("%0t: entry r%0d%0d expected %0d actual %0d", $time,
                     k / 3, k % 3, $signed(want[k]), $signed(got[k]));
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[euler_to_rotation_matrix] ERROR");
      $finish;
    end
  end

  // drive one beat and hold it until taken
  task automatic send_angles(input logic [2:0] order, input logic [15:0] ax,
                             input logic [15:0] ay, input logic [15:0] az);
    start <= 1'b1;
    cmd <= order;
    angle_x <= ax;
    angle_y <= ay;
    angle_z <= az;
    @(posedge clk);
    while (busy) @(posedge clk);
    // random idle burst after the beat
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++)
      send_angles(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                  16'($urandom));
  endtask

  task automatic test_directed();
    logic [15:0] edges [8];
    edges = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff,
              16'(HALF_PI_Q13 - 1), 16'(HALF_PI_Q13), 16'(-HALF_PI_Q13),
              16'(-HALF_PI_Q13 + 1)};
    // every order code, unused ones included
    for (int o = 0; o < 8; o++)
      send_angles(3'(o), 16'd4000, -16'sd9000, 16'd20000);
    // extremes and pi/2 fold thresholds on each axis
    for (int e = 0; e < 8; e++)
      send_angles(eul_pkg::ORD_XYZ, edges[e], edges[(e + 3) % 8], edges[(e + 5) % 8]);
    send_angles(eul_pkg::ORD_ZYX, 16'h0000, 16'h0000, 16'h0000);
    send_angles(eul_pkg::ORD_YZX, 16'h7fff, 16'h8000, 16'h7fff);
  endtask

  // hold off the sender until the pipeline drains
  task automatic test_drain_pause();
    send_random(20);
    start <= 1'b0;
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    send_random(20);
  endtask

  task automatic test_random_idle();
    idle_allowed = 1'b1;
    send_random(260);
    idle_allowed = 1'b0;
  endtask

  task automatic test_random_back_to_back();
    send_random(130);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    idle_allowed = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    angle_x = '0;
    angle_y = '0;
    angle_z = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_drain_pause();
    test_random_idle();
    test_random_back_to_back();

    start <= 1'b0;
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && expected_mats.size() == 0) begin
      $display("[euler_to_rotation_matrix] OK");
    end else begin
      $display("[euler_to_rotation_matrix] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/eul_pkg.sv
rtl/eul_cordic.sv
rtl/eul_matrix.sv
rtl/euler_to_rotation_matrix.sv
bench/euler_to_rotation_matrix_tb.sv
